[rtl/bqeq_pkg.sv]
// Shared constants and types for the biquad cascade equalizer.
// No dependencies.
package bqeq_pkg;
  localparam int BANDS = 10;
  localparam int CHANNELS = 2;
  localparam int SAMPLE_BITS = 24;
  localparam int COEF_BITS = 24;
  localparam int COEF_FRAC_BITS = 20;
  localparam int NCOEF = 5;
  localparam int BAND_W = 4;
  localparam int SEL_W = 3;
  localparam int ACC_W = SAMPLE_BITS + COEF_BITS + 4;

  localparam logic REQ_SAMPLE = 1'b0;
  localparam logic REQ_COEF = 1'b1;

  localparam logic [SEL_W-1:0] SEL_B0 = 3'd0;
  localparam logic [SEL_W-1:0] SEL_B1 = 3'd1;
  localparam logic [SEL_W-1:0] SEL_B2 = 3'd2;
  localparam logic [SEL_W-1:0] SEL_A1 = 3'd3;
  localparam logic [SEL_W-1:0] SEL_A2 = 3'd4;

  typedef logic signed [SAMPLE_BITS-1:0] smp_t;
  typedef logic signed [COEF_BITS-1:0] coef_t;

  // coefficient write broadcast to every cell
  typedef struct packed {
    logic             en;
    logic [BAND_W-1:0] band;
    logic [SEL_W-1:0]  sel;
    coef_t             value;
  } cwr_t;

  // round half up and saturate an accumulator
  function automatic smp_t round_sat(input logic signed [ACC_W-1:0] acc);
    logic signed [ACC_W-1:0] v;
    logic signed [ACC_W-1:0] hi;
    logic signed [ACC_W-1:0] lo;
    v = (acc + (ACC_W'(1) <<< (COEF_FRAC_BITS - 1))) >>> COEF_FRAC_BITS;
    hi = ACC_W'((64'sd1 <<< (SAMPLE_BITS - 1)) - 1);
    lo = -hi - ACC_W'(1);
    if (v > hi) return hi[SAMPLE_BITS-1:0];
    if (v < lo) return lo[SAMPLE_BITS-1:0];
    return v[SAMPLE_BITS-1:0];
  endfunction
endpackage

[rtl/bqeq_cell.sv]
// One biquad band: coefficients, per-channel history, one shared MAC.
// Depends on bqeq_pkg.
module bqeq_cell
  import bqeq_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic [BAND_W-1:0] band_id,
  input  cwr_t              cwr,
  input  logic              in_valid,
  input  smp_t              in_x,
  input  logic              in_ch,
  output logic              out_valid,
  output smp_t              out_y,
  output logic              out_ch
);
  coef_t coef [NCOEF];
  smp_t  hist [CHANNELS][4];
  logic [NCOEF:0] phase;          // one-hot over the five taps plus finish
  logic busy;
  logic ch;
  smp_t x;
  logic signed [ACC_W-1:0] acc;
  logic signed [ACC_W-1:0] prod;
  logic signed [SAMPLE_BITS+COEF_BITS-1:0] mul;
  logic fb_tap;
  coef_t c_sel;
  smp_t  d_sel;
  smp_t  y;

  always_comb begin
    c_sel = coef[0];
    d_sel = x;
    if (phase[1]) begin c_sel = coef[1]; d_sel = hist[ch][0]; end
    if (phase[2]) begin c_sel = coef[2]; d_sel = hist[ch][1]; end
    if (phase[3]) begin c_sel = coef[3]; d_sel = hist[ch][2]; end
    if (phase[4]) begin c_sel = coef[4]; d_sel = hist[ch][3]; end
    // feedback taps are subtracted from the accumulator
    fb_tap = phase[3] || phase[4];
    mul = c_sel * d_sel;
    prod = ACC_W'(mul);
    y = round_sat(acc);
  end

  always_ff @(posedge clk) begin
    out_valid <= 1'b0;
    if (rst) begin
      busy <= 1'b0;
      phase <= '0;
      for (int i = 0; i < NCOEF; i++) coef[i] <= (i == 0) ? coef_t'(1 << COEF_FRAC_BITS) : '0;
      for (int c = 0; c < CHANNELS; c++)
        for (int k = 0; k < 4; k++) hist[c][k] <= '0;
    end else begin
      if (cwr.en && cwr.band == band_id && cwr.sel <= SEL_A2)
        coef[cwr.sel] <= cwr.value;
      if (!busy && in_valid) begin
        busy <= 1'b1;
        phase <= (NCOEF+1)'(1);
        x <= in_x;
        ch <= in_ch;
        acc <= '0;
      end else if (busy) begin
        if (phase[NCOEF]) begin
          busy <= 1'b0;
          phase <= '0;
          hist[ch][1] <= hist[ch][0];
          hist[ch][0] <= x;
          hist[ch][3] <= hist[ch][2];
          hist[ch][2] <= y;
          out_valid <= 1'b1;
          out_y <= y;
          out_ch <= ch;
        end else begin
          acc <= fb_tap ? acc - prod : acc + prod;
          phase <= phase << 1;
        end
      end
    end
  end

  assert property (@(posedge clk) disable iff (rst) $onehot0(phase));
  assert property (@(posedge clk) disable iff (rst) busy |-> $onehot(phase));
  assert property (@(posedge clk) disable iff (rst) out_valid |-> !busy);
endmodule

[rtl/biquad_cascade_eq.sv]
// Biquad cascade equalizer: ten bqeq_cell stages in a chain.
// Each sample passes through every band's five-tap MAC in turn; one sample is
// in flight and the next word waits until the result leaves, so the equalizer
// cannot take a new sample before it is through with the last one.
// Coefficient words are accepted only while no sample is in flight. Synchronous
// active-high reset restores passthrough coefficients and clears history.
// Depends on bqeq_pkg, bqeq_cell.
module biquad_cascade_eq
  import bqeq_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [55:0] s_tdata,   // channel, sample_in, band, coef_select, coef_value
  input  logic        s_tuser,   // req_type
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // sample_out, channel_out, pad
  output logic        m_tuser
);
  logic busy;
  logic [BANDS:0] v;
  smp_t d [BANDS+1];
  logic c [BANDS+1];
  cwr_t cwr;
  logic acc_s;

  assign s_tready = !busy && !m_tvalid;
  assign acc_s = s_tvalid && s_tready;
  assign m_tuser = 1'b0;
  always_comb begin
    cwr.en = acc_s && s_tuser == REQ_COEF;
    cwr.band = s_tdata[28:25];
    cwr.sel = s_tdata[31:29];
    cwr.value = s_tdata[55:32];
  end
  assign v[0] = acc_s && s_tuser == REQ_SAMPLE;
  assign d[0] = s_tdata[24:1];
  assign c[0] = s_tdata[0];

  for (genvar b = 0; b < BANDS; b++) begin : g_cell
    bqeq_cell u_cell (
      .clk(clk), .rst(rst), .band_id(BAND_W'(b)), .cwr(cwr),
      .in_valid(v[b]), .in_x(d[b]), .in_ch(c[b]),
      .out_valid(v[b+1]), .out_y(d[b+1]), .out_ch(c[b+1])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (v[0]) busy <= 1'b1;
      if (v[BANDS]) begin
        busy <= 1'b0;
        m_tvalid <= 1'b1;
        m_tdata <= {7'd0, c[BANDS], d[BANDS]};
      end else if (m_tready) m_tvalid <= 1'b0;
    end
  end

  assert property (@(posedge clk) disable iff (rst) acc_s |-> !busy);
  assert property (@(posedge clk) disable iff (rst) v[BANDS] |-> busy);
  assert property (@(posedge clk) disable iff (rst) $onehot0(v));
endmodule
